@@ hdl/isbe_pkg.sv @@
`default_nettype none
package isbe_pkg;

  typedef logic [7:0] byte_t;

  // The width of the rx_count field is set by the receive ring depth
  localparam int RX_DEPTH = 16;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);

  localparam logic [6:0] OWN_ADDR_RESET = 7'd8;
  localparam logic [7:0] GENERAL_CALL   = 8'h00;

  // Commands
  localparam logic [1:0] CMD_START    = 2'd0;
  localparam logic [1:0] CMD_OVERFLOW = 2'd1;
  localparam logic [1:0] CMD_PUSH     = 2'd2;
  localparam logic [1:0] CMD_POP      = 2'd3;

  // Shifter actions
  localparam logic [2:0] ACT_NONE         = 3'd0;
  localparam logic [2:0] ACT_WAIT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND_ACK     = 3'd2;
  localparam logic [2:0] ACT_RECV_BYTE    = 3'd3;
  localparam logic [2:0] ACT_SEND_BYTE    = 3'd4;
  localparam logic [2:0] ACT_RECV_ACK     = 3'd5;
  localparam logic [2:0] ACT_ADDR_RESTART = 3'd6;
  localparam logic [2:0] ACT_ADDR_START   = 3'd7;

  typedef struct packed {
    logic [1:0] command;
    byte_t      bus_byte;
    logic       stop_seen;
    byte_t      host_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]       bus_action;
    byte_t            tx_byte;
    byte_t            host_data;
    logic             host_data_valid;
    logic             tx_full;
    logic             read_request;
    logic             transfer_done;
    logic             rx_overrun;
    logic [RX_CW-1:0] rx_count;
  } out_t;

endpackage
`default_nettype wire

@@ hdl/isbe_ring.sv @@
`default_nettype none
module isbe_ring #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire isbe_pkg::byte_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output isbe_pkg::byte_t      rd_data
);
  import isbe_pkg::*;

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hdl/i2c_slave_byte_engine_top.sv @@
`default_nettype none
// Byte-level I2C slave sequencer. One transaction (start event, shift counter
// overflow, reply push or receive pop) is taken every clock cycle unless
// in_stall is high. The first stage updates the sequencer state, reads both
// rings and registers the result; the second merges the registered ring read
// data into the output register, since the ring read port is registered.
// The reply ring holds TX_DEPTH-1 bytes, the receive ring 16. own_address
// resets to 8 and is written through cfg_wr_en/cfg_wr_data; the user must do
// so only while no transaction is outstanding; the block does not enforce it.
module i2c_slave_byte_engine_top #(
  parameter int TX_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [6:0]     cfg_wr_data,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire isbe_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output isbe_pkg::out_t      out_data
);
  import isbe_pkg::*;

  localparam int TX_AW = $clog2(TX_DEPTH);

  localparam logic [2:0] PH_ADDR      = 3'd0;
  localparam logic [2:0] PH_SEND      = 3'd1;
  localparam logic [2:0] PH_GET_ACK   = 3'd2;
  localparam logic [2:0] PH_CHECK_ACK = 3'd3;
  localparam logic [2:0] PH_RECV      = 3'd4;
  localparam logic [2:0] PH_STORE     = 3'd5;

  logic [6:0]       own_addr_r;
  logic [2:0]       phase_r, phase_nxt;
  logic             listen_r, listen_nxt;
  logic [RX_AW-1:0] rx_wr_r, rx_wr_nxt;
  logic [RX_AW-1:0] rx_rd_r, rx_rd_nxt;
  logic [RX_CW-1:0] rx_fill_r, rx_fill_nxt;
  logic [TX_AW-1:0] tx_wr_r, tx_wr_nxt;
  logic [TX_AW-1:0] tx_rd_r, tx_rd_nxt;
  logic [TX_AW-1:0] tx_wr_inc, tx_rd_inc;
  logic             rx_we, tx_we;

  out_t  s1_r, s1_nxt;
  logic  s1_valid_r;
  out_t  out_r, out_nxt;
  logic  out_valid_r;
  byte_t rx_rd_data, tx_rd_data;

  logic in_acc, out_adv, s1_move;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  assign tx_wr_inc = (tx_wr_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_r + 1'b1;
  assign tx_rd_inc = (tx_rd_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    listen_nxt  = listen_r;
    rx_wr_nxt   = rx_wr_r;
    rx_rd_nxt   = rx_rd_r;
    rx_fill_nxt = rx_fill_r;
    tx_wr_nxt   = tx_wr_r;
    tx_rd_nxt   = tx_rd_r;
    rx_we       = 1'b0;
    tx_we       = 1'b0;
    s1_nxt      = '0;
    s1_nxt.bus_action = ACT_NONE;

    case (in_data.command)
      CMD_START: begin
        phase_nxt = PH_ADDR;
        if (in_data.stop_seen) begin
          listen_nxt        = 1'b0;
          s1_nxt.bus_action = ACT_ADDR_START;
        end else begin
          listen_nxt        = 1'b1;
          s1_nxt.bus_action = ACT_ADDR_RESTART;
        end
      end
      CMD_OVERFLOW: begin
        if (listen_r) begin
          case (phase_r)
            PH_ADDR: begin
              if (in_data.bus_byte == GENERAL_CALL ||
                  in_data.bus_byte[7:1] == own_addr_r) begin
                if (in_data.bus_byte[0]) begin
                  s1_nxt.read_request = 1'b1;
                  phase_nxt           = PH_SEND;
                end else begin
                  phase_nxt = PH_RECV;
                end
                s1_nxt.bus_action = ACT_SEND_ACK;
              end else begin
                listen_nxt        = 1'b0;
                s1_nxt.bus_action = ACT_WAIT_START;
              end
            end
            PH_SEND, PH_CHECK_ACK: begin
              // nonzero ack bit from the master is a NACK: end the transfer
              if (phase_r == PH_CHECK_ACK && in_data.bus_byte != 8'h00) begin
                s1_nxt.transfer_done = 1'b1;
                listen_nxt           = 1'b0;
                s1_nxt.bus_action    = ACT_WAIT_START;
              end else if (tx_wr_r != tx_rd_r) begin
                tx_rd_nxt         = tx_rd_inc;
                phase_nxt         = PH_GET_ACK;
                s1_nxt.bus_action = ACT_SEND_BYTE;
              end else begin
                listen_nxt        = 1'b0;
                s1_nxt.bus_action = ACT_WAIT_START;
              end
            end
            PH_GET_ACK: begin
              phase_nxt         = PH_CHECK_ACK;
              s1_nxt.bus_action = ACT_RECV_ACK;
            end
            PH_RECV: begin
              phase_nxt         = PH_STORE;
              s1_nxt.bus_action = ACT_RECV_BYTE;
            end
            PH_STORE: begin
              if (rx_fill_r < RX_CW'(RX_DEPTH)) begin
                rx_we       = 1'b1;
                rx_wr_nxt   = rx_wr_r + 1'b1;
                rx_fill_nxt = rx_fill_r + 1'b1;
              end else begin
                s1_nxt.rx_overrun = 1'b1;
              end
              phase_nxt         = PH_RECV;
              s1_nxt.bus_action = ACT_SEND_ACK;
            end
            default: begin
              phase_nxt         = PH_ADDR;
              listen_nxt        = 1'b0;
              s1_nxt.bus_action = ACT_WAIT_START;
            end
          endcase
        end
      end
      CMD_PUSH: begin
        // one slot stays empty so that full and empty differ
        if (tx_wr_inc == tx_rd_r) begin
          s1_nxt.tx_full = 1'b1;
        end else begin
          tx_we     = 1'b1;
          tx_wr_nxt = tx_wr_inc;
        end
      end
      CMD_POP: begin
        if (rx_fill_r != '0) begin
          s1_nxt.host_data_valid = 1'b1;
          rx_rd_nxt              = rx_rd_r + 1'b1;
          rx_fill_nxt            = rx_fill_r - 1'b1;
        end
      end
      default: begin
        s1_nxt.bus_action = ACT_NONE;
      end
    endcase

    s1_nxt.rx_count = rx_fill_nxt;
  end

  isbe_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
    .clk     (clk),
    .wr_en   (in_acc && rx_we),
    .wr_addr (rx_wr_r),
    .wr_data (in_data.bus_byte),
    .rd_en   (in_acc),
    .rd_addr (rx_rd_r),
    .rd_data (rx_rd_data)
  );

  isbe_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
    .clk     (clk),
    .wr_en   (in_acc && tx_we),
    .wr_addr (tx_wr_r),
    .wr_data (in_data.host_byte),
    .rd_en   (in_acc),
    .rd_addr (tx_rd_r),
    .rd_data (tx_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= OWN_ADDR_RESET;
      phase_r    <= PH_ADDR;
      listen_r   <= 1'b0;
      rx_wr_r    <= '0;
      rx_rd_r    <= '0;
      rx_fill_r  <= '0;
      tx_wr_r    <= '0;
      tx_rd_r    <= '0;
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        own_addr_r <= cfg_wr_data;
      end
      if (in_acc) begin
        phase_r   <= phase_nxt;
        listen_r  <= listen_nxt;
        rx_wr_r   <= rx_wr_nxt;
        rx_rd_r   <= rx_rd_nxt;
        rx_fill_r <= rx_fill_nxt;
        tx_wr_r   <= tx_wr_nxt;
        tx_rd_r   <= tx_rd_nxt;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // merge the registered ring read data into the result
  always_comb begin
    out_nxt           = s1_r;
    out_nxt.tx_byte   = (s1_r.bus_action == ACT_SEND_BYTE) ? tx_rd_data : 8'h00;
    out_nxt.host_data = s1_r.host_data_valid ? rx_rd_data : 8'h00;
  end

  // payload stages: hold while stalled
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_fill_r <= RX_CW'(RX_DEPTH))
    else $error("receive fill count beyond ring depth");

  a_fill_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_fill_r != RX_CW'(RX_DEPTH)) |-> ((rx_wr_r - rx_rd_r) == rx_fill_r[RX_AW-1:0]))
    else $error("receive fill count disagrees with ring pointers");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bus_action != ACT_SEND_BYTE) |-> (out_r.tx_byte == 8'h00))
    else $error("tx_byte set without a send action");

  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.host_data_valid) |-> (out_r.host_data == 8'h00))
    else $error("host_data set without a valid pop");

endmodule
`default_nettype wire

@@ dv/i2c_byte_engine_checker.sv @@
`timescale 1ns / 100ps
module i2c_byte_engine_checker #(
  parameter int TX_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [6:0]     cfg_wr_data,
  input  logic           in_valid,
  input  logic           in_stall,
  input  isbe_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  isbe_pkg::out_t out_data,
  output int unsigned    mismatches,
  output int unsigned    outstanding
);
  import isbe_pkg::*;

  typedef enum logic [2:0] {
    SEQ_ADDR      = 3'd0,
    SEQ_SEND      = 3'd1,
    SEQ_GET_ACK   = 3'd2,
    SEQ_CHECK_ACK = 3'd3,
    SEQ_RECV      = 3'd4,
    SEQ_STORE     = 3'd5
  } seq_phase_t;

  logic [6:0]       own_address;
  seq_phase_t       phase;
  logic             listening;
  byte_t            rx_ring [RX_DEPTH];
  logic [RX_AW-1:0] rx_wr;
  logic [RX_AW-1:0] rx_rd;
  logic [RX_CW-1:0] rx_fill;
  byte_t            tx_ring [TX_DEPTH];
  int unsigned      tx_wr;
  int unsigned      tx_rd;

  out_t responses_due [$];

  // Hand the next queued reply byte to the shifter, or give up on the transfer
  function automatic logic [2:0] pull_reply(inout out_t r);
    if (tx_wr != tx_rd) begin
      r.tx_byte = tx_ring[tx_rd];
      tx_rd = (tx_rd + 1) % TX_DEPTH;
      phase = SEQ_GET_ACK;
      return ACT_SEND_BYTE;
    end
    listening = 1'b0;
    return ACT_WAIT_START;
  endfunction

  function automatic out_t engine_respond(in_t ev);
    out_t        r;
    logic [2:0]  act;
    int unsigned nxt;
    r = '0;
    act = ACT_NONE;
    case (ev.command)
      CMD_START: begin
        phase = SEQ_ADDR;
        listening = !ev.stop_seen;
        act = ev.stop_seen ? ACT_ADDR_START : ACT_ADDR_RESTART;
      end
      CMD_OVERFLOW: begin
        // overflows outside an addressed transfer are dropped
        if (listening) begin
          case (phase)
            SEQ_ADDR: begin
              if (ev.bus_byte == GENERAL_CALL || ev.bus_byte[7:1] == own_address) begin
                r.read_request = ev.bus_byte[0];
                if (ev.bus_byte[0]) begin
                  phase = SEQ_SEND;
                end else begin
                  phase = SEQ_RECV;
                end
                act = ACT_SEND_ACK;
              end else begin
                listening = 1'b0;
                act = ACT_WAIT_START;
              end
            end
            SEQ_CHECK_ACK: begin
              if (ev.bus_byte != 8'h00) begin
                r.transfer_done = 1'b1;
                listening = 1'b0;
                act = ACT_WAIT_START;
              end else begin
                act = pull_reply(r);
              end
            end
            SEQ_SEND: act = pull_reply(r);
            SEQ_GET_ACK: begin
              phase = SEQ_CHECK_ACK;
              act = ACT_RECV_ACK;
            end
            SEQ_RECV: begin
              phase = SEQ_STORE;
              act = ACT_RECV_BYTE;
            end
            SEQ_STORE: begin
              if (rx_fill < RX_DEPTH) begin
                rx_ring[rx_wr] = ev.bus_byte;
                rx_wr = rx_wr + 1'b1;
                rx_fill = rx_fill + 1'b1;
              end else begin
                r.rx_overrun = 1'b1;
              end
              phase = SEQ_RECV;
              act = ACT_SEND_ACK;
            end
            default: begin
              phase = SEQ_ADDR;
              listening = 1'b0;
              act = ACT_WAIT_START;
            end
          endcase
        end
      end
      CMD_PUSH: begin
        // one slot stays empty to tell full from empty
        nxt = (tx_wr + 1) % TX_DEPTH;
        if (nxt == tx_rd) begin
          r.tx_full = 1'b1;
        end else begin
          tx_ring[tx_wr] = ev.host_byte;
          tx_wr = nxt;
        end
      end
      default: begin
        if (rx_fill != 0) begin
          r.host_data = rx_ring[rx_rd];
          r.host_data_valid = 1'b1;
          rx_rd = rx_rd + 1'b1;
          rx_fill = rx_fill - 1'b1;
        end
      end
    endcase
    r.bus_action = act;
    r.rx_count = rx_fill;
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    bit   ok;
    if (!rst_n) begin
      own_address = OWN_ADDR_RESET;
      phase = SEQ_ADDR;
      listening = 1'b0;
      rx_wr = '0;
      rx_rd = '0;
      rx_fill = '0;
      tx_wr = 0;
      tx_rd = 0;
      mismatches = 0;
      responses_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (responses_due.size() == 0) begin
          $display("%0t: result expected none got %0h", $time, out_data);
          mismatches++;
        end else begin
          want = responses_due.pop_front();
          ok = 1'b1;
          ok &= field_ok("bus_action", want.bus_action, out_data.bus_action);
          ok &= field_ok("tx_byte", want.tx_byte, out_data.tx_byte);
          ok &= field_ok("host_data", want.host_data, out_data.host_data);
          ok &= field_ok("host_data_valid", want.host_data_valid,
                         out_data.host_data_valid);
          ok &= field_ok("tx_full", want.tx_full, out_data.tx_full);
          ok &= field_ok("read_request", want.read_request, out_data.read_request);
          ok &= field_ok("transfer_done", want.transfer_done, out_data.transfer_done);
          ok &= field_ok("rx_overrun", want.rx_overrun, out_data.rx_overrun);
          ok &= field_ok("rx_count", want.rx_count, out_data.rx_count);
          if (!ok) mismatches++;
        end
      end
      if (in_valid && !in_stall) responses_due.push_back(engine_respond(in_data));
      if (cfg_wr_en) own_address = cfg_wr_data;
    end
    outstanding = responses_due.size();
  end

endmodule

@@ dv/tb_i2c_slave_byte_engine_top.sv @@
`timescale 1ns / 100ps
module tb_i2c_slave_byte_engine_top;
  import isbe_pkg::*;

  localparam int TX_DEPTH     = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 250;
  localparam int LONG_HOLD    = 80;
  localparam int SETTLE       = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = OWN_ADDR_RESET;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycles = 0;
  int unsigned offered = 0;
  int unsigned hold_req = 0;
  bit          quiet = 1'b0;

  always #5 clk = ~clk;

  i2c_slave_byte_engine_top #(.TX_DEPTH(TX_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  i2c_byte_engine_checker #(.TX_DEPTH(TX_DEPTH)) engine_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL i2c_slave_byte_engine_top");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic byte_t rnd8();
    return byte_t'($urandom);
  endfunction

  // Called and returns at a falling edge; valid stays high into the next call
  task automatic offer(logic [1:0] cmd, byte_t bus, logic stop, byte_t host);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = '{command: cmd, bus_byte: bus, stop_seen: stop, host_byte: host};
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    offered++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_done;
    stall_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_done) begin
        holds_done++;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        stall_left = idle_len();
      end
      if (stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned n;
    int unsigned k;
    int unsigned goal;
    int unsigned pick;
    byte_t       b;
    logic [6:0]  own;
    own = OWN_ADDR_RESET;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pop, idle overflow, stop, mismatch, empty reply ring,
    // read with ACK then NACK, general call write, pop
    offer(CMD_POP, 8'h00, 1'b0, 8'hFF);
    offer(CMD_OVERFLOW, 8'hFF, 1'b1, 8'h00);
    offer(CMD_START, 8'h00, 1'b1, 8'h00);
    offer(CMD_OVERFLOW, {own, 1'b0}, 1'b0, 8'h00);
    offer(CMD_START, 8'hFF, 1'b0, 8'hFF);
    offer(CMD_OVERFLOW, 8'hFE, 1'b0, 8'h00);
    offer(CMD_START, 8'h00, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, {own, 1'b1}, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, 8'h55, 1'b0, 8'h00);
    offer(CMD_PUSH, 8'h00, 1'b0, 8'hFF);
    offer(CMD_PUSH, 8'hFF, 1'b1, 8'h00);
    offer(CMD_START, 8'h00, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, {own, 1'b1}, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, 8'h00, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, 8'h00, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, 8'h00, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, 8'h00, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, 8'h01, 1'b0, 8'h00);
    offer(CMD_START, 8'h00, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, GENERAL_CALL, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, 8'h3C, 1'b0, 8'h00);
    offer(CMD_OVERFLOW, 8'hFF, 1'b0, 8'h00);
    offer(CMD_POP, 8'h00, 1'b0, 8'h00);
    offer(CMD_START, 8'h00, 1'b1, 8'h00);

    for (p = 0; p < 5; p++) begin
      drain();
      if (p == 0) own = 7'd127;
      else if (p == 1) own = 7'd1;
      else own = 7'($urandom_range(126, 2));
      cfg_wr_en = 1'b1;
      cfg_wr_data = own;
      @(negedge clk);
      cfg_wr_en = 1'b0;
      // on pass p == 2, back-to-back traffic while the result side is held off
      quiet = (p == 2);
      if (p == 2) hold_req++;
      goal = offered + PHASE_ITEMS;
      while (offered < goal) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          offer(CMD_START, rnd8(), 1'b0, rnd8());
          k = $urandom_range(9);
          b = (k == 0) ? GENERAL_CALL : (k == 1) ? rnd8() : {own, 1'b0};
          offer(CMD_OVERFLOW, b, 1'($urandom), rnd8());
          n = ($urandom_range(6) == 0) ? $urandom_range(24, 12) : $urandom_range(6);
          repeat (n) begin
            offer(CMD_OVERFLOW, rnd8(), 1'($urandom), rnd8());
            offer(CMD_OVERFLOW, rnd8(), 1'($urandom), rnd8());
            if ($urandom_range(7) == 0) offer(CMD_POP, rnd8(), 1'($urandom), rnd8());
          end
          if ($urandom_range(1) != 0) offer(CMD_START, rnd8(), 1'b1, rnd8());
        end else if (pick < 55) begin
          k = ($urandom_range(4) == 0) ? $urandom_range(18, 10) : $urandom_range(5);
          repeat (k) offer(CMD_PUSH, rnd8(), 1'($urandom), rnd8());
          offer(CMD_START, rnd8(), 1'b0, rnd8());
          b = ($urandom_range(9) == 0) ? rnd8() : {own, 1'b1};
          offer(CMD_OVERFLOW, b, 1'($urandom), rnd8());
          offer(CMD_OVERFLOW, rnd8(), 1'($urandom), rnd8());
          n = $urandom_range(k + 1);
          repeat (n) begin
            offer(CMD_OVERFLOW, rnd8(), 1'($urandom), rnd8());
            offer(CMD_OVERFLOW, 8'h00, 1'($urandom), rnd8());
          end
          offer(CMD_OVERFLOW, rnd8(), 1'($urandom), rnd8());
          offer(CMD_OVERFLOW, byte_t'($urandom_range(255, 1)), 1'($urandom), rnd8());
        end else if (pick < 70) begin
          repeat ($urandom_range(20, 1)) offer(CMD_POP, rnd8(), 1'($urandom), rnd8());
        end else if (pick < 80) begin
          repeat ($urandom_range(20, 1)) offer(CMD_PUSH, rnd8(), 1'($urandom), rnd8());
        end else if (pick < 85) begin
          offer(CMD_START, rnd8(), 1'b1, rnd8());
          offer(CMD_OVERFLOW, {own, 1'($urandom)}, 1'($urandom), rnd8());
        end else begin
          repeat ($urandom_range(6, 1))
            offer(2'($urandom), rnd8(), 1'($urandom), rnd8());
        end
      end
    end
    quiet = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("PASS i2c_slave_byte_engine_top");
    end else begin
      $display("FAIL i2c_slave_byte_engine_top");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/isbe_pkg.sv
hdl/isbe_ring.sv
hdl/i2c_slave_byte_engine_top.sv
dv/i2c_byte_engine_checker.sv
dv/tb_i2c_slave_byte_engine_top.sv
